[design/lmsc_pkg.sv]
// Shared constants, types and helper functions of the min-sum check-node unit.
`timescale 1ns / 1ps
package lmsc_pkg;

  localparam int VALUE_BITS     = 12;
  localparam int MAG_W          = VALUE_BITS - 1;
  localparam int MAX_ROW_WEIGHT = 32;
  localparam int IDX_W          = $clog2(MAX_ROW_WEIGHT);
  localparam int CNT_W          = $clog2(MAX_ROW_WEIGHT + 1);
  localparam int POS_W          = 5;
  localparam int ADDR_W         = IDX_W + 1;
  localparam int MEM_DEPTH      = 2 * MAX_ROW_WEIGHT;
  localparam int QUEUE_DEPTH    = 2;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  localparam mag_t   MAG_MAX   = {MAG_W{1'b1}};
  localparam value_t VALUE_MIN = {1'b1, {MAG_W{1'b0}}};

  typedef struct packed {
    logic   bank;
    cnt_t   count;
    mag_t   min1;
    mag_t   min2;
    idx_t   min_pos;
    logic   parity;
    value_t partner;
    value_t own;
  } desc_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    value_t data;
  } wr_t;

  function automatic mag_t mag_of(value_t x);
    value_t neg;
    mag_t   res;
    neg = -x;
    if (x == VALUE_MIN) begin
      res = MAG_MAX;
    end else if (x[VALUE_BITS-1]) begin
      res = neg[MAG_W-1:0];
    end else begin
      res = x[MAG_W-1:0];
    end
    return res;
  endfunction

  function automatic value_t apply_sign(mag_t m, logic neg);
    value_t v;
    v = {1'b0, m};
    return neg ? -v : v;
  endfunction

endpackage

[design/ldpc_min_sum_check_node.sv]
// Top level of the min-sum check-node unit: front end, row queue and back end.
//
// The input channel takes one bit-to-check message word per handshake; the word
// flagged with in_row_end closes the row and carries the partner transverse value.
// Messages beyond the 32nd of a row are dropped from the minima, parity and store.
// After the closing word the output channel delivers one word per edge, in edge
// order, each with the extrinsic value, the edge position, the row's own
// transverse value and a last-of-row flag.
// With an idle back end, the first result of a row passes through the row queue, the
// store read stage and the output register after its closing word is accepted, and
// results then follow at one word per cycle while out_ready is high.
// Input accepts one word per cycle. The message store holds two row banks and the
// queue holds two row summaries, so the front end stalls only when two finished
// rows still wait for the back end to read them out.
// A stalled receiver holds the output register; the back end then stops reading
// the store and the front end keeps filling the free bank.
// Synchronous reset clears the row accumulators, the queue and the output valid.
`timescale 1ns / 1ps
module ldpc_min_sum_check_node import lmsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  value_t           in_edge_msg,
  input  value_t           in_partner_value,
  input  logic             in_row_end,
  output logic             out_valid,
  input  logic             out_ready,
  output value_t           out_extrinsic_value,
  output logic [POS_W-1:0] out_edge_position,
  output value_t           out_own_transverse,
  output logic             out_last_of_row
);

  logic  q_can_push;
  logic  q_push;
  desc_t q_desc;
  logic  q_pop;
  logic  q_head_valid;
  desc_t q_head;
  wr_t   wr;

  lmsc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_edge_msg      (in_edge_msg),
    .in_partner_value (in_partner_value),
    .in_row_end       (in_row_end),
    .q_can_push       (q_can_push),
    .q_push           (q_push),
    .q_desc           (q_desc),
    .wr               (wr)
  );

  lmsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_desc),
    .can_push   (q_can_push),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  lmsc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .wr                  (wr),
    .head_valid          (q_head_valid),
    .head                (q_head),
    .pop                 (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_extrinsic_value (out_extrinsic_value),
    .out_edge_position   (out_edge_position),
    .out_own_transverse  (out_own_transverse),
    .out_last_of_row     (out_last_of_row)
  );

endmodule

[design/lmsc_front.sv]
// Front end: accepts messages, stores them and tracks the row minima and sign parity.
`timescale 1ns / 1ps
module lmsc_front import lmsc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  value_t in_edge_msg,
  input  value_t in_partner_value,
  input  logic   in_row_end,
  input  logic   q_can_push,
  output logic   q_push,
  output desc_t  q_desc,
  output wr_t    wr
);

  cnt_t count_r, count_nxt;
  mag_t min1_r, min1_nxt;
  mag_t min2_r, min2_nxt;
  idx_t pos_r, pos_nxt;
  logic par_r, par_nxt;
  logic bank_r, bank_nxt;

  logic accept;
  logic store;
  mag_t m;
  cnt_t upd_count;
  mag_t upd_min1;
  mag_t upd_min2;
  idx_t upd_pos;
  logic upd_par;

  assign in_ready = q_can_push;
  assign accept   = in_valid && in_ready;
  assign store    = (count_r < cnt_t'(MAX_ROW_WEIGHT));
  assign m        = mag_of(in_edge_msg);

  always_comb begin
    upd_count = count_r;
    upd_min1  = min1_r;
    upd_min2  = min2_r;
    upd_pos   = pos_r;
    upd_par   = par_r;
    if (store) begin
      upd_count = count_r + cnt_t'(1);
      upd_par   = par_r ^ in_edge_msg[VALUE_BITS-1];
      if (m < min1_r) begin
        upd_min2 = min1_r;
        upd_min1 = m;
        upd_pos  = count_r[IDX_W-1:0];
      end else if (m < min2_r) begin
        upd_min2 = m;
      end
    end
  end

  always_comb begin
    q_push           = accept && in_row_end;
    q_desc.bank      = bank_r;
    q_desc.count     = upd_count;
    q_desc.min1      = upd_min1;
    q_desc.min2      = upd_min2;
    q_desc.min_pos   = upd_pos;
    q_desc.parity    = upd_par;
    q_desc.partner   = in_partner_value;
    q_desc.own       = (count_r == '0) ? in_edge_msg : apply_sign(upd_min1, upd_par);
    wr.en            = accept && store;
    wr.addr          = {bank_r, count_r[IDX_W-1:0]};
    wr.data          = in_edge_msg;
  end

  always_comb begin
    count_nxt = count_r;
    min1_nxt  = min1_r;
    min2_nxt  = min2_r;
    pos_nxt   = pos_r;
    par_nxt   = par_r;
    bank_nxt  = bank_r;
    if (accept) begin
      if (in_row_end) begin
        count_nxt = '0;
        min1_nxt  = MAG_MAX;
        min2_nxt  = MAG_MAX;
        pos_nxt   = '0;
        par_nxt   = 1'b0;
        bank_nxt  = ~bank_r;
      end else begin
        count_nxt = upd_count;
        min1_nxt  = upd_min1;
        min2_nxt  = upd_min2;
        pos_nxt   = upd_pos;
        par_nxt   = upd_par;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min1_r  <= MAG_MAX;
      min2_r  <= MAG_MAX;
      pos_r   <= '0;
      par_r   <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      min1_r  <= min1_nxt;
      min2_r  <= min2_nxt;
      pos_r   <= pos_nxt;
      par_r   <= par_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

[design/lmsc_queue.sv]
// Two-entry queue of finished row summaries between the front and back ends.
`timescale 1ns / 1ps
module lmsc_queue import lmsc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  can_push,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head
);

  desc_t entry_r [QUEUE_DEPTH];
  logic  head_r, head_nxt;
  logic  tail;
  logic [1:0] cnt_r, cnt_nxt;

  assign can_push   = (cnt_r < 2'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != 2'd0);
  assign head       = entry_r[head_r];
  assign tail       = head_r ^ cnt_r[0];

  always_comb begin
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
    head_nxt = pop ? ~head_r : head_r;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[tail] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      head_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
    end
  end

endmodule

[design/lmsc_back.sv]
// Back end: holds the message store and emits one extrinsic word per edge of a row.
`timescale 1ns / 1ps
module lmsc_back import lmsc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  wr_t           wr,
  input  logic          head_valid,
  input  desc_t         head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output value_t        out_extrinsic_value,
  output logic [POS_W-1:0] out_edge_position,
  output value_t        out_own_transverse,
  output logic          out_last_of_row
);

  value_t mem [MEM_DEPTH];
  value_t mem_q;

  idx_t  k_r, k_nxt;
  logic  s1_valid_r, s1_valid_nxt;
  desc_t s1_desc_r;
  idx_t  s1_k_r;
  logic  s1_last_r;

  logic   out_valid_r, out_valid_nxt;
  value_t ext_r;
  idx_t   pos_r;
  value_t own_r;
  logic   last_r;

  logic   advance;
  logic   issue;
  logic   last_issue;
  addr_t  raddr;
  value_t ext_calc;

  assign advance    = !out_valid_r || out_ready;
  assign issue      = head_valid && (!s1_valid_r || advance);
  assign last_issue = (cnt_t'({1'b0, k_r}) + cnt_t'(1) == head.count);
  assign raddr      = {head.bank, k_r};
  assign pop        = issue && last_issue;

  always_comb begin
    k_nxt = k_r;
    if (issue) begin
      k_nxt = last_issue ? '0 : k_r + idx_t'(1);
    end
    if (issue) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    mag_t m;
    mag_t pm;
    mag_t mm;
    logic s;
    logic neg;
    m   = (s1_k_r == s1_desc_r.min_pos) ? s1_desc_r.min2 : s1_desc_r.min1;
    s   = s1_desc_r.parity ^ mem_q[VALUE_BITS-1];
    pm  = mag_of(s1_desc_r.partner);
    mm  = (m < pm) ? m : pm;
    neg = (s && (m != '0)) != s1_desc_r.partner[VALUE_BITS-1];
    if (s1_desc_r.count == cnt_t'(1)) begin
      ext_calc = s1_desc_r.partner;
    end else if (s1_desc_r.partner != '0) begin
      ext_calc = apply_sign(mm, neg);
    end else begin
      ext_calc = apply_sign(m, s);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (issue) begin
      mem_q     <= mem[raddr];
      s1_desc_r <= head;
      s1_k_r    <= k_r;
      s1_last_r <= last_issue;
    end
    if (advance && s1_valid_r) begin
      ext_r  <= ext_calc;
      pos_r  <= s1_k_r;
      own_r  <= s1_desc_r.own;
      last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_extrinsic_value = ext_r;
  assign out_edge_position   = POS_W'(pos_r);
  assign out_own_transverse  = own_r;
  assign out_last_of_row     = last_r;

endmodule

[test/tb.sv]
// Self-checking testbench for the min-sum check-node unit with randomized pacing on both sides.
`timescale 1ns / 1ps
module tb import lmsc_pkg::*; ();

  localparam int LIMIT_CYCLES  = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_TARGET = 210;

  typedef enum int {PACE_NONE, PACE_FULL, PACE_SPARSE} pace_t;
  typedef enum int {VAL_ANY, VAL_NEAR_ZERO, VAL_CORNER} val_style_t;

  typedef struct {
    value_t           ext;
    logic [POS_W-1:0] pos;
    value_t           own;
    logic             last;
  } edge_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  value_t           in_edge_msg = '0;
  value_t           in_partner_value = '0;
  logic             in_row_end = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  value_t           out_extrinsic_value;
  logic [POS_W-1:0] out_edge_position;
  value_t           out_own_transverse;
  logic             out_last_of_row;

  edge_result_t expected_results[$];
  value_t       row_store[MAX_ROW_WEIGHT];
  int           row_len = 0;
  int           row_min1 = int'(MAG_MAX);
  int           row_min2 = int'(MAG_MAX);
  int           row_min_pos = 0;
  logic         row_parity = 1'b0;

  pace_t in_pace = PACE_NONE;
  pace_t out_pace = PACE_NONE;
  int    items_sent = 0;
  int    mismatch_count = 0;
  int    cycle_count = 0;
  int    out_hold = 0;

  ldpc_min_sum_check_node u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_edge_msg         (in_edge_msg),
    .in_partner_value    (in_partner_value),
    .in_row_end          (in_row_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_extrinsic_value (out_extrinsic_value),
    .out_edge_position   (out_edge_position),
    .out_own_transverse  (out_own_transverse),
    .out_last_of_row     (out_last_of_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int draw_wait(pace_t p);
    case (p)
      PACE_FULL:   return $urandom_range(0, 13);
      PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
      default:     return 0;
    endcase
  endfunction

  function automatic int magnitude(value_t x);
    int v;
    v = int'(x);
    if (v < 0) v = -v;
    return (v > int'(MAG_MAX)) ? int'(MAG_MAX) : v;
  endfunction

  function automatic value_t with_sign(int m, logic neg);
    value_t r;
    r = value_t'(neg ? -m : m);
    return r;
  endfunction

  // Folds one message into the row summary and, on the closing word, queues the row's results.
  function automatic void predict_check_row(value_t msg, value_t partner, logic last);
    int           m;
    int           n;
    value_t       own;
    value_t       ext;
    edge_result_t res;
    if (row_len < MAX_ROW_WEIGHT) begin
      m = magnitude(msg);
      row_store[row_len] = msg;
      row_parity ^= msg[VALUE_BITS-1];
      if (m < row_min1) begin
        row_min2 = row_min1;
        row_min1 = m;
        row_min_pos = row_len;
      end else if (m < row_min2) begin
        row_min2 = m;
      end
      row_len++;
    end
    if (!last) return;
    n = row_len;
    own = (n == 1) ? row_store[0] : with_sign(row_min1, row_parity);
    for (int k = 0; k < n; k++) begin
      if (n == 1) begin
        ext = partner;
      end else begin
        ext = with_sign((k == row_min_pos) ? row_min2 : row_min1,
                        row_parity ^ row_store[k][VALUE_BITS-1]);
        if (partner != 0) begin
          ext = with_sign((magnitude(ext) < magnitude(partner)) ? magnitude(ext)
                                                                : magnitude(partner),
                          ext[VALUE_BITS-1] ^ partner[VALUE_BITS-1]);
        end
      end
      res.ext = ext;
      res.pos = k[POS_W-1:0];
      res.own = own;
      res.last = (k == n - 1);
      expected_results.push_back(res);
    end
    row_len = 0;
    row_min1 = int'(MAG_MAX);
    row_min2 = int'(MAG_MAX);
    row_min_pos = 0;
    row_parity = 1'b0;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_word(value_t msg, value_t partner, logic last);
    int gap;
    gap = draw_wait(in_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_edge_msg <= msg;
    in_partner_value <= partner;
    in_row_end <= last;
    predict_check_row(msg, partner, last);
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic value_t rand_value(val_style_t style);
    value_t v;
    case (style)
      VAL_NEAR_ZERO: v = value_t'(int'($urandom_range(0, 16)) - 8);
      VAL_CORNER: begin
        case ($urandom_range(0, 5))
          0: v = VALUE_MIN;
          1: v = value_t'(int'(VALUE_MIN) + 1);
          2: v = value_t'(-1);
          3: v = value_t'(0);
          4: v = value_t'(1);
          default: v = {1'b0, MAG_MAX};
        endcase
      end
      default: v = value_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_row(int len);
    val_style_t row_style;
    val_style_t style;
    value_t     partner;
    row_style = val_style_t'($urandom_range(VAL_ANY, VAL_CORNER));
    for (int i = 0; i < len; i++) begin
      style = ($urandom_range(0, 3) == 0) ? val_style_t'($urandom_range(VAL_ANY, VAL_CORNER))
                                          : row_style;
      if (i == len - 1 && $urandom_range(0, 3) == 0) begin
        partner = '0;
      end else begin
        partner = rand_value(val_style_t'($urandom_range(VAL_ANY, VAL_CORNER)));
      end
      send_word(rand_value(style), partner, i == len - 1);
    end
  endtask

  task automatic test_single_edge_rows();
    send_word({1'b0, MAG_MAX}, value_t'(0), 1'b1);
    send_word(VALUE_MIN, VALUE_MIN, 1'b1);
    send_word(value_t'(0), value_t'(5), 1'b1);
    send_word(value_t'(-1), {1'b0, MAG_MAX}, 1'b1);
    send_word(value_t'(-5), value_t'(0), 1'b1);
  endtask

  task automatic test_saturation_and_signs();
    send_word(VALUE_MIN, value_t'(123), 1'b0);
    send_word({1'b0, MAG_MAX}, VALUE_MIN, 1'b0);
    send_word(value_t'(0), value_t'(-77), 1'b0);
    send_word(value_t'(-1), VALUE_MIN, 1'b1);
    send_word(VALUE_MIN, value_t'(0), 1'b0);
    send_word(VALUE_MIN, value_t'(0), 1'b0);
    send_word({1'b0, MAG_MAX}, {1'b0, MAG_MAX}, 1'b1);
  endtask

  task automatic test_min_ties();
    send_word(value_t'(3), value_t'(9), 1'b0);
    send_word(value_t'(-3), value_t'(9), 1'b0);
    send_word(value_t'(3), value_t'(9), 1'b0);
    send_word(value_t'(7), value_t'(-1), 1'b1);
  endtask

  task automatic test_partner_zero();
    send_word(value_t'(-9), value_t'(1), 1'b0);
    send_word(value_t'(4), value_t'(1), 1'b0);
    send_word(VALUE_MIN, value_t'(0), 1'b1);
  endtask

  task automatic test_random_rows();
    int len;
    while (items_sent < RANDOM_TARGET) begin
      in_pace = pace_t'($urandom_range(PACE_NONE, PACE_SPARSE));
      out_pace = pace_t'($urandom_range(PACE_NONE, PACE_SPARSE));
      case ($urandom_range(0, 9))
        0: len = $urandom_range(9, MAX_ROW_WEIGHT);
        1: len = MAX_ROW_WEIGHT;
        default: len = $urandom_range(1, 8);
      endcase
      send_row(len);
    end
  endtask

  task automatic test_overflow_rows();
    repeat (3) begin
      in_pace = pace_t'($urandom_range(PACE_NONE, PACE_SPARSE));
      out_pace = pace_t'($urandom_range(PACE_NONE, PACE_SPARSE));
      send_row($urandom_range(MAX_ROW_WEIGHT + 1, MAX_ROW_WEIGHT + 8));
    end
  endtask

  always @(posedge clk) begin : receiver_pacing
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        gap = draw_wait(out_pace);
        if (gap > 0) begin
          out_ready <= 1'b0;
          out_hold <= gap - 1;
        end
      end
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    edge_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word ext=%0d pos=%0d",
                                  out_extrinsic_value, out_edge_position));
      end else begin
        want = expected_results.pop_front();
        if (out_extrinsic_value !== want.ext)
          report_mismatch($sformatf("extrinsic pos=%0d got %0d want %0d", want.pos,
                                    out_extrinsic_value, want.ext));
        if (out_edge_position !== want.pos)
          report_mismatch($sformatf("edge position got %0d want %0d",
                                    out_edge_position, want.pos));
        if (out_own_transverse !== want.own)
          report_mismatch($sformatf("own transverse pos=%0d got %0d want %0d", want.pos,
                                    out_own_transverse, want.own));
        if (out_last_of_row !== want.last)
          report_mismatch($sformatf("last flag pos=%0d got %0b want %0b", want.pos,
                                    out_last_of_row, want.last));
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_single_edge_rows();
    out_pace = PACE_FULL;
    test_saturation_and_signs();
    in_pace = PACE_FULL;
    test_min_ties();
    out_pace = PACE_SPARSE;
    test_partner_zero();
    test_random_rows();
    test_overflow_rows();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
design/lmsc_pkg.sv
design/lmsc_front.sv
design/lmsc_queue.sv
design/lmsc_back.sv
design/ldpc_min_sum_check_node.sv
test/tb.sv
